/* sv/int8_cosine_topk_search_macros.svh */
// Assertion macros for the cosine top-k search RTL.
`ifndef INT8_COSINE_TOPK_SEARCH_MACROS_SVH
`define INT8_COSINE_TOPK_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ICS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ICS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/ics_pkg.sv */
// Shared types, constants and width functions of the cosine top-k search.
`default_nettype none
package ics_pkg;

    localparam int MAX_DIM_DEF  = 256;
    localparam int MAX_KEEP_DEF = 16;

    localparam int OPCODE_W = 2;
    localparam int ELEM_W   = 8;
    localparam int LEN_W    = 9;
    localparam int KEEP_W   = 5;
    localparam int CFG_W    = 9;
    localparam int IDX_W    = 32;
    localparam int DIST_W   = 18;
    localparam int ENTRY_W  = DIST_W + IDX_W;
    localparam int BSQ_W    = 35;
    localparam int ASHIFT   = 34;

    localparam logic [DIST_W-1:0] ONE_Q16 = 18'd65536;
    localparam logic [DIST_W-1:0] TWO_Q16 = 18'd131072;
    localparam logic [DIST_W:0]   B_BIAS  = 19'd131073;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_DATA   = 2'd1,
        OP_FINISH = 2'd2
    } t_opcode;

    typedef enum logic {
        CFG_VECTOR_LENGTH = 1'b0,
        CFG_KEEP_COUNT    = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {T_IDLE, T_RD, T_DIST, T_OFFER, T_FINISH} t_top_state;
    typedef enum logic [2:0] {
        D_IDLE, D_SQD, D_PRD, D_CHK, D_SQB, D_MUL, D_CMP, D_DONE
    } t_dist_state;
    typedef enum logic [1:0] {L_IDLE, L_SCAN, L_EMIT} t_list_state;

    typedef struct packed {
        logic              offer;
        logic              finish;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  index;
    } t_list_req;

    function automatic int energy_w(input int max_dim);
        return $clog2(max_dim * 16384 + 1);
    endfunction

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int len_w(input int max_dim);
        return ($clog2(max_dim + 1) > LEN_W) ? $clog2(max_dim + 1) : LEN_W;
    endfunction

    function automatic int keep_w(input int max_keep);
        return ($clog2(max_keep + 1) > KEEP_W) ? $clog2(max_keep + 1) : KEEP_W;
    endfunction

endpackage
`default_nettype wire

/* sv/ics_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ics_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = ics_pkg::addr_w(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/ics_dist.sv */
// Cosine distance unit: bisection on the Q2.16 result with a shift-add product.
`default_nettype none
module ics_dist #(
    parameter int MAX_DIM = ics_pkg::MAX_DIM_DEF,
    localparam int EW     = ics_pkg::energy_w(MAX_DIM)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [EW:0]            i_dot,
    input  wire logic        [EW-1:0]          i_qe,
    input  wire logic        [EW-1:0]          i_de,
    output logic                               o_done,
    output logic        [ics_pkg::DIST_W-1:0]  o_dist
);
    localparam int MW = (EW > ics_pkg::DIST_W) ? EW : ics_pkg::DIST_W;
    localparam int CW = 2 * EW + ics_pkg::BSQ_W;
    localparam int DW = ics_pkg::DIST_W;

    ics_pkg::t_dist_state r_state, n_state;

    logic [EW-1:0]      r_mag, r_qe, r_de;
    logic               r_dot_pos;
    logic [CW-1:0]      r_a2, r_pp, r_acc;
    logic [2*EW-1:0]    r_prod;
    logic [ics_pkg::BSQ_W-1:0] r_b2;
    logic [DW-1:0]      r_lo, r_hi, r_mid, r_bmag;

    logic [MW-1:0]      w_ma, w_mb;
    logic [2*MW-1:0]    w_mp;
    logic [DW:0]        w_sum, w_two_mid;
    logic [DW-1:0]      w_mid, w_bmag;
    logic               w_bpos, w_cond;

    assign w_mp      = w_ma * w_mb;
    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi} + (DW+1)'(1);
    assign w_mid     = w_sum[DW:1];
    assign w_two_mid = {w_mid, 1'b0};
    assign w_bpos    = (w_mid <= ics_pkg::ONE_Q16);
    assign w_bmag    = w_bpos ? DW'(ics_pkg::B_BIAS - w_two_mid)
                              : DW'(w_two_mid - ics_pkg::B_BIAS);
    assign w_cond    = r_dot_pos ? (r_a2 <= r_acc) : (r_acc <= r_a2);
    assign o_dist    = r_lo;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ics_pkg::D_IDLE: if (i_start) n_state = ics_pkg::D_SQD;
            ics_pkg::D_SQD:  n_state = (r_qe == '0 || r_de == '0) ? ics_pkg::D_DONE
                                                                 : ics_pkg::D_PRD;
            ics_pkg::D_PRD:  n_state = ics_pkg::D_CHK;
            ics_pkg::D_CHK: begin
                if (r_lo >= r_hi) begin
                    n_state = ics_pkg::D_DONE;
                end else if (r_dot_pos == w_bpos) begin
                    n_state = ics_pkg::D_SQB;
                end
            end
            ics_pkg::D_SQB:  n_state = ics_pkg::D_MUL;
            ics_pkg::D_MUL:  if (r_b2 == '0) n_state = ics_pkg::D_CMP;
            ics_pkg::D_CMP:  n_state = ics_pkg::D_CHK;
            ics_pkg::D_DONE: n_state = ics_pkg::D_IDLE;
            default:         n_state = ics_pkg::D_IDLE;
        endcase
    end

    always_comb begin
        o_done = 1'b0;
        w_ma   = MW'(r_bmag);
        w_mb   = MW'(r_bmag);
        unique case (r_state)
            ics_pkg::D_SQD: begin
                w_ma = MW'(r_mag);
                w_mb = MW'(r_mag);
            end
            ics_pkg::D_PRD: begin
                w_ma = MW'(r_qe);
                w_mb = MW'(r_de);
            end
            ics_pkg::D_DONE: o_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ics_pkg::D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ics_pkg::D_IDLE: begin
                r_dot_pos <= (i_dot > 0);
                r_mag     <= (i_dot < 0) ? EW'(-i_dot) : EW'(i_dot);
                r_qe      <= i_qe;
                r_de      <= i_de;
            end
            ics_pkg::D_SQD: begin
                r_a2 <= {CW'(w_mp[2*EW-1:0])} << ics_pkg::ASHIFT;
                r_lo <= ics_pkg::ONE_Q16;
            end
            ics_pkg::D_PRD: begin
                r_prod <= w_mp[2*EW-1:0];
                r_lo   <= '0;
                r_hi   <= ics_pkg::TWO_Q16;
            end
            ics_pkg::D_CHK: begin
                // Sign alone settles the step when a and b differ in sign.
                if (r_lo < r_hi) begin
                    if (!r_dot_pos && w_bpos) begin
                        r_lo <= w_mid;
                    end else if (r_dot_pos && !w_bpos) begin
                        r_hi <= w_mid - DW'(1);
                    end
                end
                r_mid  <= w_mid;
                r_bmag <= w_bmag;
            end
            ics_pkg::D_SQB: begin
                r_b2  <= w_mp[ics_pkg::BSQ_W-1:0];
                r_pp  <= CW'(r_prod);
                r_acc <= '0;
            end
            ics_pkg::D_MUL: begin
                if (r_b2[0]) begin
                    r_acc <= r_acc + r_pp;
                end
                r_b2 <= r_b2 >> 1;
                r_pp <= r_pp << 1;
            end
            ics_pkg::D_CMP: begin
                if (w_cond) begin
                    r_lo <= r_mid;
                end else begin
                    r_hi <= r_mid - DW'(1);
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* sv/ics_topk.sv */
// Best-k list held in a RAM: insertion, worst-entry replacement and sorted read-out.
`default_nettype none
module ics_topk #(
    parameter int MAX_KEEP = ics_pkg::MAX_KEEP_DEF,
    localparam int KCW     = ics_pkg::keep_w(MAX_KEEP)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ics_pkg::t_list_req           i_req,
    input  wire logic [KCW-1:0]               i_keep,
    output logic                              o_done,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [ics_pkg::IDX_W-1:0]         o_vector_index,
    output logic [ics_pkg::DIST_W-1:0]        o_distance,
    output logic                              o_last_result
);
    localparam int KA = ics_pkg::addr_w(MAX_KEEP);
    localparam int DW = ics_pkg::DIST_W;
    localparam int IW = ics_pkg::IDX_W;

    ics_pkg::t_list_state r_state, n_state;

    logic [KCW-1:0] r_fill, r_rd_addr, r_cnt, r_n;
    logic           r_pend, r_have, r_max_mode, r_prev_ok, r_done;
    logic [KA-1:0]  r_tag, r_ba;
    logic [DW-1:0]  r_dist, r_bd, r_pd;
    logic [IW-1:0]  r_index, r_bi, r_pi;
    logic           r_out_valid, r_out_last;
    logic [DW-1:0]  r_out_dist;
    logic [IW-1:0]  r_out_index;

    logic                        w_we, w_issue, w_scan_end, w_better, w_elig, w_append;
    logic [KA-1:0]               w_waddr;
    logic [ics_pkg::ENTRY_W-1:0] w_wdata, w_rdata;
    logic [DW-1:0]               w_rd_d;
    logic [IW-1:0]               w_rd_i;
    logic [KCW-1:0]              w_emit_n;

    ics_ram #(.WIDTH(ics_pkg::ENTRY_W), .DEPTH(MAX_KEEP)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_addr[KA-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd_d     = w_rdata[ics_pkg::ENTRY_W-1:IW];
    assign w_rd_i     = w_rdata[IW-1:0];
    assign w_emit_n   = (r_fill < i_keep) ? r_fill : i_keep;
    assign w_append   = (r_fill < i_keep);
    assign w_issue    = (r_state == ics_pkg::L_SCAN) && (r_rd_addr < r_fill);
    assign w_scan_end = (r_state == ics_pkg::L_SCAN) && !w_issue && !r_pend;
    assign w_elig     = !r_prev_ok || (w_rd_d > r_pd) || (w_rd_d == r_pd && w_rd_i > r_pi);

    always_comb begin
        if (r_max_mode) begin
            w_better = !r_have || (w_rd_d > r_bd) || (w_rd_d == r_bd && w_rd_i > r_bi);
        end else begin
            w_better = w_elig &&
                       (!r_have || (w_rd_d < r_bd) || (w_rd_d == r_bd && w_rd_i < r_bi));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ics_pkg::L_IDLE: begin
                if (i_req.offer && !w_append && r_fill != '0) begin
                    n_state = ics_pkg::L_SCAN;
                end else if (i_req.finish && w_emit_n != '0) begin
                    n_state = ics_pkg::L_SCAN;
                end
            end
            ics_pkg::L_SCAN: begin
                if (w_scan_end) n_state = r_max_mode ? ics_pkg::L_IDLE : ics_pkg::L_EMIT;
            end
            ics_pkg::L_EMIT: begin
                if (r_out_valid && i_ready) begin
                    n_state = r_out_last ? ics_pkg::L_IDLE : ics_pkg::L_SCAN;
                end
            end
            default: n_state = ics_pkg::L_IDLE;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ba;
        w_wdata = {r_dist, r_index};
        unique case (r_state)
            ics_pkg::L_IDLE: begin
                w_we    = i_req.offer && w_append;
                w_waddr = r_fill[KA-1:0];
                w_wdata = {i_req.distance, i_req.index};
            end
            ics_pkg::L_SCAN: w_we = w_scan_end && r_max_mode && (r_dist < r_bd);
            default: ;
        endcase
    end

    assign o_done         = r_done;
    assign o_valid        = r_out_valid;
    assign o_vector_index = r_out_index;
    assign o_distance     = r_out_dist;
    assign o_last_result  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ics_pkg::L_IDLE;
            r_fill      <= '0;
            r_done      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_rd_addr   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            r_pend  <= w_issue;
            r_tag   <= r_rd_addr[KA-1:0];
            case (r_state)
                ics_pkg::L_IDLE: begin
                    r_have    <= 1'b0;
                    r_rd_addr <= '0;
                    if (i_req.offer) begin
                        r_dist     <= i_req.distance;
                        r_index    <= i_req.index;
                        r_max_mode <= 1'b1;
                        if (w_append) begin
                            r_fill <= r_fill + KCW'(1);
                            r_done <= 1'b1;
                        end else if (r_fill == '0) begin
                            r_done <= 1'b1;
                        end
                    end else if (i_req.finish) begin
                        r_max_mode <= 1'b0;
                        r_prev_ok  <= 1'b0;
                        r_cnt      <= '0;
                        r_n        <= w_emit_n;
                        if (w_emit_n == '0) begin
                            r_fill <= '0;
                            r_done <= 1'b1;
                        end
                    end
                end
                ics_pkg::L_SCAN: begin
                    if (w_issue) r_rd_addr <= r_rd_addr + KCW'(1);
                    if (r_pend && w_better) begin
                        r_have <= 1'b1;
                        r_bd   <= w_rd_d;
                        r_bi   <= w_rd_i;
                        r_ba   <= r_tag;
                    end
                    if (w_scan_end) begin
                        if (r_max_mode) begin
                            r_done <= 1'b1;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_dist  <= r_bd;
                            r_out_index <= r_bi;
                            r_out_last  <= (r_cnt + KCW'(1) == r_n);
                            r_prev_ok   <= 1'b1;
                            r_pd        <= r_bd;
                            r_pi        <= r_bi;
                        end
                    end
                end
                ics_pkg::L_EMIT: begin
                    if (r_out_valid && i_ready) begin
                        r_out_valid <= 1'b0;
                        r_have      <= 1'b0;
                        r_rd_addr   <= '0;
                        if (r_out_last) begin
                            r_fill <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + KCW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/int8_cosine_topk_search.sv */
// Top level of the int8 cosine top-k nearest-neighbour search.
//
//  channel   signals                                   transfer when
//  --------  ----------------------------------------  ------------------------
//  config    i_cfg_we i_cfg_index i_cfg_data           i_cfg_we high
//  input     i_valid/o_ready i_opcode i_element        i_valid && o_ready
//  result    o_valid/i_ready o_vector_index            o_valid && i_ready
//            o_distance o_last_result
//
//  A query element is written straight to the query RAM; a database element goes
//  through a query RAM read, then multiply-accumulate. The last element of a vector
//  starts the distance unit: up to 18 bisection steps, where a step not settled by
//  sign runs a shift-add product over the bits of b*b (at most 34); the list update
//  follows, a direct write when appending, a scan of the list when replacing. A
//  finish scans the list once per reported entry and waits on any result stall.
//  Reset is synchronous and clears counters and energies; neither RAM is cleared.
`default_nettype none
`include "int8_cosine_topk_search_macros.svh"
module int8_cosine_topk_search #(
    parameter int MAX_DIM  = ics_pkg::MAX_DIM_DEF,
    parameter int MAX_KEEP = ics_pkg::MAX_KEEP_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_index,
    input  wire logic [ics_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [ics_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire logic signed [ics_pkg::ELEM_W-1:0] i_element,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [ics_pkg::IDX_W-1:0]             o_vector_index,
    output logic [ics_pkg::DIST_W-1:0]            o_distance,
    output logic                                  o_last_result
);
    localparam int EW  = ics_pkg::energy_w(MAX_DIM);
    localparam int AW  = ics_pkg::addr_w(MAX_DIM);
    localparam int LW  = ics_pkg::len_w(MAX_DIM);
    localparam int KCW = ics_pkg::keep_w(MAX_KEEP);

    ics_pkg::t_top_state r_state, n_state;

    logic [ics_pkg::LEN_W-1:0]  r_len;
    logic [ics_pkg::KEEP_W-1:0] r_keep;
    logic [LW-1:0]              r_qpos, r_epos;
    logic [EW-1:0]              r_qe, r_ve;
    logic signed [EW:0]         r_dot;
    logic [ics_pkg::IDX_W-1:0]  r_vcount;
    logic signed [ics_pkg::ELEM_W-1:0] r_elem;

    logic [LW-1:0]   w_len, w_len_ext, w_qpos_eff, w_qpos_inc, w_epos_inc;
    logic [KCW-1:0]  w_keep, w_keep_ext;
    logic            w_acc, w_data_acc, w_vec_end, w_dist_start, w_dist_done, w_list_done;
    logic signed [15:0] w_in_sq, w_el_sq, w_qprod;
    logic [ics_pkg::ELEM_W-1:0] w_qdata;
    logic signed [EW:0] w_dot_next;
    logic [EW-1:0]      w_ve_next;
    logic [ics_pkg::DIST_W-1:0] w_dist;
    ics_pkg::t_list_req w_req;

    // Clamp the registers to their usable ranges.
    assign w_len_ext  = LW'(r_len);
    assign w_len      = (r_len == '0) ? LW'(1)
                      : ((w_len_ext > LW'(MAX_DIM)) ? LW'(MAX_DIM) : w_len_ext);
    assign w_keep_ext = KCW'(r_keep);
    assign w_keep     = (r_keep == '0) ? KCW'(1)
                      : ((w_keep_ext > KCW'(MAX_KEEP)) ? KCW'(MAX_KEEP) : w_keep_ext);

    assign w_acc      = i_valid && o_ready;
    assign w_data_acc = w_acc && (i_opcode == ics_pkg::OP_DATA);
    assign w_qpos_eff = (r_qpos >= w_len) ? '0 : r_qpos;
    assign w_qpos_inc = w_qpos_eff + LW'(1);
    assign w_epos_inc = r_epos + LW'(1);
    assign w_vec_end  = (w_epos_inc >= w_len);

    assign w_in_sq    = i_element * i_element;
    assign w_el_sq    = r_elem * r_elem;
    assign w_qprod    = $signed(w_qdata) * r_elem;
    assign w_dot_next = r_dot + (EW+1)'(w_qprod);
    assign w_ve_next  = r_ve + EW'($unsigned(w_el_sq));

    // Query store: written by query elements, read at the element position.
    ics_ram #(.WIDTH(ics_pkg::ELEM_W), .DEPTH(MAX_DIM)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && i_opcode == ics_pkg::OP_QUERY),
        .i_waddr (w_qpos_eff[AW-1:0]),
        .i_wdata (i_element),
        .i_raddr (r_epos[AW-1:0]),
        .o_rdata (w_qdata)
    );

    ics_dist #(.MAX_DIM(MAX_DIM)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dist_start),
        .i_dot   (w_dot_next),
        .i_qe    (r_qe),
        .i_de    (w_ve_next),
        .o_done  (w_dist_done),
        .o_dist  (w_dist)
    );

    ics_topk #(.MAX_KEEP(MAX_KEEP)) u_topk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .i_keep         (w_keep),
        .o_done         (w_list_done),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_vector_index (o_vector_index),
        .o_distance     (o_distance),
        .o_last_result  (o_last_result)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ics_pkg::T_IDLE: begin
                if (w_acc) begin
                    case (ics_pkg::t_opcode'(i_opcode))
                        ics_pkg::OP_DATA:   n_state = ics_pkg::T_RD;
                        ics_pkg::OP_FINISH: n_state = ics_pkg::T_FINISH;
                        default:            n_state = ics_pkg::T_IDLE;
                    endcase
                end
            end
            ics_pkg::T_RD:     n_state = w_vec_end ? ics_pkg::T_DIST : ics_pkg::T_IDLE;
            ics_pkg::T_DIST:   if (w_dist_done) n_state = ics_pkg::T_OFFER;
            ics_pkg::T_OFFER,
            ics_pkg::T_FINISH: if (w_list_done) n_state = ics_pkg::T_IDLE;
            default:           n_state = ics_pkg::T_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = (r_state == ics_pkg::T_IDLE);
        w_dist_start   = (r_state == ics_pkg::T_RD) && w_vec_end;
        w_req.offer    = (r_state == ics_pkg::T_DIST) && w_dist_done;
        w_req.finish   = (r_state == ics_pkg::T_IDLE) && w_acc &&
                         (i_opcode == ics_pkg::OP_FINISH);
        w_req.distance = w_dist;
        w_req.index    = r_vcount;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_elem <= i_element;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ics_pkg::T_IDLE;
            r_len    <= ics_pkg::LEN_W'(256);
            r_keep   <= ics_pkg::KEEP_W'(16);
            r_qpos   <= '0;
            r_qe     <= '0;
            r_epos   <= '0;
            r_dot    <= '0;
            r_ve     <= '0;
            r_vcount <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (ics_pkg::t_cfg_index'(i_cfg_index))
                    ics_pkg::CFG_VECTOR_LENGTH: r_len  <= i_cfg_data;
                    ics_pkg::CFG_KEEP_COUNT:    r_keep <= i_cfg_data[ics_pkg::KEEP_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ics_pkg::T_IDLE: begin
                    if (w_acc && i_opcode == ics_pkg::OP_QUERY) begin
                        // Position 0 restarts the query energy; wrap at the length.
                        r_qe   <= ((w_qpos_eff == '0) ? '0 : r_qe) + EW'($unsigned(w_in_sq));
                        r_qpos <= (w_qpos_inc >= w_len) ? '0 : w_qpos_inc;
                    end else if (w_req.finish) begin
                        r_vcount <= '0;
                        r_epos   <= '0;
                        r_dot    <= '0;
                        r_ve     <= '0;
                    end
                end
                ics_pkg::T_RD: begin
                    if (w_vec_end) begin
                        r_epos <= '0;
                        r_dot  <= '0;
                        r_ve   <= '0;
                    end else begin
                        r_epos <= w_epos_inc;
                        r_dot  <= w_dot_next;
                        r_ve   <= w_ve_next;
                    end
                end
                ics_pkg::T_DIST: begin
                    if (w_dist_done) r_vcount <= r_vcount + 32'd1;
                end
                default: ;
            endcase
        end
    end

    // Results appear only while a finish is being reported.
    `ICS_ASSERT_IMP(a_result_in_finish, i_clk, i_rst_n, o_valid, r_state == ics_pkg::T_FINISH)
    // The distance unit completes only while the controller waits for it.
    `ICS_ASSERT_IMP(a_dist_done_waits, i_clk, i_rst_n, w_dist_done, r_state == ics_pkg::T_DIST)
    // A database element goes on to the query RAM read.
    `ICS_ASSERT_NXT(a_data_reads, i_clk, i_rst_n, w_data_acc, r_state == ics_pkg::T_RD)
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the int8 cosine top-k nearest-neighbour search.
`default_nettype none
module testbench;
    import ics_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         HOLD_OFF  = 1000;  // distance unit worst case plus list update

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_hit;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_opcode = '0;
    logic signed [7:0] i_element = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [IDX_W-1:0]  o_vector_index;
    logic [DIST_W-1:0] o_distance;
    logic              o_last_result;

    int8_cosine_topk_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_opcode(i_opcode), .i_element(i_element),
        .o_valid(o_valid), .i_ready(i_ready), .o_vector_index(o_vector_index),
        .o_distance(o_distance), .o_last_result(o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the search
    logic [8:0]        len_reg;
    logic [4:0]        keep_reg;
    logic signed [7:0] query_mem [256];
    int                query_pos;
    longint            query_sq;
    int                elem_pos;
    longint            dot_sum;
    longint            vec_sq;
    logic [31:0]       vec_count;
    logic [17:0]       near_dist [16];
    logic [31:0]       near_idx [16];
    int                near_fill;

    t_hit pending_hits[$];
    int   error_count = 0;
    int   burst_left = 0;

    function automatic int cur_len();
        if (len_reg == 0) return 1;
        if (len_reg > 256) return 256;
        return int'(len_reg);
    endfunction

    function automatic int cur_keep();
        if (keep_reg == 0) return 1;
        if (keep_reg > 16) return 16;
        return int'(keep_reg);
    endfunction

    // Exact test of 131072*dot <= b*sqrt(p), with b odd and p > 0
    function automatic bit under_bound(longint dot, longint b, longint unsigned p);
        longint        a;
        logic [127:0]  ua;
        logic [127:0]  ub;
        logic [127:0]  lhs;
        logic [127:0]  rhs;
        a = dot * 131072;
        if (a <= 0 && b > 0) return 1'b1;
        if (a > 0 && b < 0) return 1'b0;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        lhs = ua * ua;
        rhs = ub * ub * 128'(p);
        if (a > 0) return lhs <= rhs;
        return rhs <= lhs;
    endfunction

    function automatic logic [17:0] cosine_q16(longint dot, longint qe, longint de);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 131072;
        if (qe == 0 || de == 0) return ONE_Q16;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (under_bound(dot, 131073 - 2 * longint'(mid), longint'(qe * de))) lo = mid;
            else hi = mid - 1;
        end
        return 18'(lo);
    endfunction

    task automatic insert_candidate(input logic [17:0] d, input logic [31:0] idx);
        int worst;
        worst = 0;
        if (near_fill < cur_keep()) begin
            near_dist[near_fill] = d;
            near_idx[near_fill] = idx;
            near_fill++;
            return;
        end
        for (int i = 1; i < near_fill; i++)
            if (near_dist[i] > near_dist[worst] ||
                (near_dist[i] == near_dist[worst] && near_idx[i] > near_idx[worst]))
                worst = i;
        if (d < near_dist[worst]) begin
            near_dist[worst] = d;
            near_idx[worst] = idx;
        end
    endtask

    task automatic predict_item(input logic [1:0] op, input logic signed [7:0] e);
        int   ord [16];
        int   best;
        int   tmp;
        int   emit;
        t_hit h;
        case (op)
            OP_QUERY: begin
                if (query_pos >= cur_len()) query_pos = 0;
                if (query_pos == 0) query_sq = 0;
                query_mem[query_pos] = e;
                query_sq += longint'(e) * longint'(e);
                query_pos++;
                if (query_pos >= cur_len()) query_pos = 0;
            end
            OP_DATA: begin
                dot_sum += longint'(query_mem[elem_pos]) * longint'(e);
                vec_sq += longint'(e) * longint'(e);
                elem_pos++;
                if (elem_pos >= cur_len()) begin
                    insert_candidate(cosine_q16(dot_sum, query_sq, vec_sq), vec_count);
                    vec_count++;
                    elem_pos = 0;
                    dot_sum = 0;
                    vec_sq = 0;
                end
            end
            OP_FINISH: begin
                for (int i = 0; i < near_fill; i++) ord[i] = i;
                for (int i = 0; i < near_fill; i++) begin
                    best = i;
                    for (int j = i + 1; j < near_fill; j++)
                        if (near_dist[ord[j]] < near_dist[ord[best]] ||
                            (near_dist[ord[j]] == near_dist[ord[best]] &&
                             near_idx[ord[j]] < near_idx[ord[best]]))
                            best = j;
                    tmp = ord[i]; ord[i] = ord[best]; ord[best] = tmp;
                end
                emit = (near_fill < cur_keep()) ? near_fill : cur_keep();
                for (int i = 0; i < emit; i++) begin
                    h.idx = near_idx[ord[i]];
                    h.distance = near_dist[ord[i]];
                    h.last = (i + 1 == emit);
                    pending_hits.insert(pending_hits.size(), h);
                end
                near_fill = 0;
                vec_count = 0;
                elem_pos = 0;
                dot_sum = 0;
                vec_sq = 0;
            end
            default: ;  // unused opcode: drop
        endcase
    endtask

    task automatic report(input string what);
        error_count++;
        if (error_count <= 40) $display("ERROR at %0t: %s", $time, what);
    endtask

    // Send one item; the sender runs in bursts with random gaps between them
    task automatic send_item(input logic [1:0] op, input logic signed [7:0] e);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_element <= e;
        do @(posedge i_clk); while (!o_ready);
        predict_item(op, e);
    endtask

    // Hold the sender until every result is in and the distance unit has drained
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_VECTOR_LENGTH) len_reg = 9'(value);
        else keep_reg = 5'(value);
    endtask

    task automatic configure(input int length, input int keep);
        drain();
        write_reg(CFG_VECTOR_LENGTH, length);
        write_reg(CFG_KEEP_COUNT, keep);
    endtask

    // 0: full range, 1: tiny values that force ties, 2: all zero
    function automatic logic signed [7:0] pick_elem(input int mode);
        case (mode)
            0: return 8'($urandom_range(0, 255));
            1: return 8'(int'($urandom_range(0, 2)) - 1);
            default: return 8'sd0;
        endcase
    endfunction

    task automatic send_vector(input logic [1:0] op, input int n, input int mode);
        for (int i = 0; i < n; i++) send_item(op, pick_elem(mode));
    endtask

    // Extreme elements, identical and opposite vectors, ties on the worst entry
    task automatic test_extremes();
        configure(2, 2);
        send_item(OP_QUERY, 8'sd127);
        send_item(OP_QUERY, -8'sd128);
        send_item(OP_DATA, 8'sd127);   send_item(OP_DATA, -8'sd128);
        send_item(OP_DATA, -8'sd128);  send_item(OP_DATA, 8'sd127);
        send_item(OP_DATA, -8'sd128);  send_item(OP_DATA, -8'sd128);
        send_item(OP_DATA, 8'sd127);   send_item(OP_DATA, -8'sd128);
        send_item(OP_DATA, 8'sd0);     send_item(OP_DATA, 8'sd0);
        send_item(OP_FINISH, 8'sd0);
    endtask

    // Zero query, empty finish, unused opcode, registers below range
    task automatic test_zero_and_range();
        configure(0, 0);
        send_item(OP_QUERY, 8'sd0);
        send_item(OP_DATA, 8'sd5);
        send_item(OP_FINISH, -8'sd1);
        send_item(OP_FINISH, 8'sd0);
        send_item(OP_UNUSED, 8'sd3);
        send_item(OP_QUERY, -8'sd7);
        send_item(OP_DATA, 8'sd7);
        send_item(OP_DATA, -8'sd7);
        send_item(OP_FINISH, 8'sd0);
    endtask

    // Length lowered while a database vector and a query are part way in
    task automatic test_length_lowered();
        configure(4, 16);
        send_vector(OP_QUERY, 4, 0);
        send_vector(OP_DATA, 3, 0);
        send_vector(OP_QUERY, 3, 0);
        configure(2, 16);
        send_item(OP_DATA, 8'sd9);
        send_item(OP_QUERY, 8'sd1);
        send_vector(OP_DATA, 2, 0);
        send_item(OP_FINISH, 8'sd0);
    endtask

    // Keep register above range: fill the widest list, then replace in it
    task automatic test_wide_list();
        configure(2, 31);
        send_vector(OP_QUERY, 2, 0);
        for (int v = 0; v < 20; v++) send_vector(OP_DATA, 2, (v % 3 == 1) ? 1 : 0);
        send_item(OP_FINISH, 8'sd0);
    endtask

    task automatic test_random_search(input int budget);
        int sent;
        int n;
        int r;
        int length;
        int keep;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(0, 9);
            length = (r < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            r = $urandom_range(0, 9);
            keep = (r == 0) ? 1 : (r == 1) ? 16 : (r == 2) ? $urandom_range(17, 31)
                 : $urandom_range(1, 15);
            configure(length, keep);
            send_vector(OP_QUERY, length, ($urandom_range(0, 9) == 0) ? 2 : 0);
            sent += length;
            for (int k = 0; k < 12 && sent < budget; k++) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    n = length;
                    send_vector(OP_DATA, n, ($urandom_range(0, 3) == 0) ? 1
                              : ($urandom_range(0, 9) == 0) ? 2 : 0);
                end else if (r < 83) begin
                    n = $urandom_range(1, length);
                    send_vector(OP_QUERY, n, 0);
                end else if (r < 88) begin
                    n = 1;
                    send_item(OP_UNUSED, pick_elem(0));
                end else if (r < 94) begin
                    n = $urandom_range(1, length);
                    send_vector(OP_DATA, n, 0);
                end else begin
                    n = 1;
                    send_item(OP_FINISH, pick_elem(0));
                end
                sent += n;
            end
            send_item(OP_FINISH, 8'sd0);
            sent++;
        end
    endtask

    // Result side stalls on a pattern of its own, changing mode now and then
    int stall_tick = 0;
    int stall_mode = 0;
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= (stall_tick % 16) < 4;
            default: i_ready <= (stall_tick % 5) != 0;
        endcase
    end

    // Compare each result transfer with the oldest expected entry
    always @(posedge i_clk) begin : check_results
        t_hit h;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_hits.size() == 0) begin
                report($sformatf("result with none expected: index %0d distance %0d",
                                 o_vector_index, o_distance));
            end else begin
                h = pending_hits.pop_front();
                if (o_vector_index !== h.idx)
                    report($sformatf("vector_index %0d, want %0d", o_vector_index, h.idx));
                if (o_distance !== h.distance)
                    report($sformatf("distance %0d, want %0d", o_distance, h.distance));
                if (o_last_result !== h.last)
                    report($sformatf("last_result %0b, want %0b", o_last_result, h.last));
            end
        end
    end

    initial begin
        len_reg = 9'd256;
        keep_reg = 5'd16;
        query_pos = 0; query_sq = 0; elem_pos = 0; dot_sum = 0; vec_sq = 0;
        vec_count = '0; near_fill = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_zero_and_range();
        test_length_lowered();
        test_random_search(60);
        test_wide_list();
        drain();
        if (error_count == 0) $display("int8_cosine_topk_search: match");
        else $display("int8_cosine_topk_search: mismatch");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("int8_cosine_topk_search: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
